### rtl/core/mfas_pkg.sv
// mfas_pkg: shared types, codes and mapping functions of the motor fault alarm supervisor
package mfas_pkg;

  // configuration register indexes
  localparam int CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DETAIL_MODE   = 3'd0,
    CFG_HOLD_MS       = 3'd1,
    CFG_OVERLOAD_CODE = 3'd2,
    CFG_VOLTAGE_CODE  = 3'd3,
    CFG_HALL_CODE     = 3'd4,
    CFG_BOARD_CODE    = 3'd5,
    CFG_HANDLE_LOST   = 3'd6,
    CFG_NO_PICTURE    = 3'd7
  } cfg_idx_t;

  localparam int CfgDataW = 16;

  // register reset values
  localparam logic        DETAIL_MODE_RST   = 1'b0;
  localparam logic [15:0] HOLD_MS_RST       = 16'd3000;
  localparam logic [7:0]  OVERLOAD_CODE_RST = 8'd5;
  localparam logic [7:0]  VOLTAGE_CODE_RST  = 8'd8;
  localparam logic [7:0]  HALL_CODE_RST     = 8'd9;
  localparam logic [7:0]  BOARD_CODE_RST    = 8'd7;
  localparam logic [7:0]  HANDLE_LOST_RST   = 8'd1;
  localparam logic [7:0]  NO_PICTURE_RST    = 8'd255;

  // raw driver fault codes
  localparam logic [7:0] ERR_NONE         = 8'd0;
  localparam logic [7:0] ERR_OVERCURRENT  = 8'd2;
  localparam logic [7:0] ERR_OVERVOLTAGE  = 8'd3;
  localparam logic [7:0] ERR_UNDERVOLTAGE = 8'd4;
  localparam logic [7:0] ERR_RUN_STALL    = 8'd5;
  localparam logic [7:0] ERR_CODE_6       = 8'd6;
  localparam logic [7:0] ERR_CODE_8       = 8'd8;
  localparam logic [7:0] ERR_CODE_9       = 8'd9;
  localparam logic [7:0] ERR_CODE_10      = 8'd10;
  localparam logic [7:0] ERR_HALL_DISC    = 8'd11;
  localparam logic [7:0] ERR_HALL_LEARN   = 8'd12;
  localparam logic [7:0] ERR_PHASE_LOSS   = 8'd14;
  localparam logic [7:0] ERR_CODE_15      = 8'd15;

  // screen picture numbers
  localparam logic [7:0] PIC_PHASE_LOSS   = 8'd84;
  localparam logic [7:0] PIC_HALL_SHARED  = 8'd86;
  localparam logic [7:0] PIC_OVERLOAD     = 8'd87;
  localparam logic [7:0] PIC_DBG_9        = 8'd91;
  localparam logic [7:0] PIC_DBG_OVERCUR  = 8'd92;
  localparam logic [7:0] PIC_DBG_HALL_D   = 8'd93;
  localparam logic [7:0] PIC_DBG_HALL_L   = 8'd94;
  localparam logic [7:0] PIC_DBG_10       = 8'd95;
  localparam logic [7:0] PIC_DBG_OVERVOLT = 8'd96;
  localparam logic [7:0] PIC_DBG_6        = 8'd97;
  localparam logic [7:0] PIC_DBG_15       = 8'd98;
  localparam logic [7:0] PIC_DBG_8        = 8'd99;

  // input item fields, lowest field last
  typedef struct packed {
    logic [7:0]  shown_alarm;
    logic        alarm_shown;
    logic        foot_running;
    logic [31:0] now_ms;
    logic [7:0]  drv_fault;
  } in_item_t;

  // result item fields, lowest field last
  typedef struct packed {
    logic       waiting_release;
    logic       stop_pumps;
    logic       stop_all_work;
    logic       clear_alarm;
    logic [7:0] picture_code;
    logic [7:0] alarm_code;
    logic       raise_alarm;
  } result_t;

  localparam int InItemW  = $bits(in_item_t);
  localparam int ResultW  = $bits(result_t);
  localparam int InDataW  = ((InItemW + 7) / 8) * 8;
  localparam int OutDataW = ((ResultW + 7) / 8) * 8;

  // alarm code for a raw fault code
  function automatic logic [7:0] map_alarm(
    input logic [7:0] err,
    input logic [7:0] overload_code,
    input logic [7:0] voltage_code,
    input logic [7:0] hall_code,
    input logic [7:0] board_code
  );
    logic [7:0] a;
    case (err)
      ERR_NONE:                          a = 8'd0;
      ERR_OVERCURRENT, ERR_RUN_STALL:    a = overload_code;
      ERR_OVERVOLTAGE, ERR_UNDERVOLTAGE: a = voltage_code;
      ERR_HALL_DISC, ERR_HALL_LEARN:     a = hall_code;
      default:                           a = board_code;
    endcase
    return a;
  endfunction

  // picture code for a raw fault code
  function automatic logic [7:0] map_picture(
    input logic [7:0] err,
    input logic       detail,
    input logic [7:0] no_pic
  );
    logic [7:0] p;
    case (err)
      ERR_PHASE_LOSS:  p = PIC_PHASE_LOSS;
      ERR_RUN_STALL:   p = PIC_OVERLOAD;
      ERR_OVERCURRENT: p = detail ? PIC_DBG_OVERCUR : PIC_OVERLOAD;
      ERR_HALL_DISC:   p = detail ? PIC_DBG_HALL_D : PIC_HALL_SHARED;
      ERR_HALL_LEARN:  p = detail ? PIC_DBG_HALL_L : PIC_HALL_SHARED;
      ERR_CODE_9:      p = detail ? PIC_DBG_9 : no_pic;
      ERR_CODE_10:     p = detail ? PIC_DBG_10 : no_pic;
      ERR_OVERVOLTAGE: p = detail ? PIC_DBG_OVERVOLT : no_pic;
      ERR_CODE_6:      p = detail ? PIC_DBG_6 : no_pic;
      ERR_CODE_15:     p = detail ? PIC_DBG_15 : no_pic;
      ERR_CODE_8:      p = detail ? PIC_DBG_8 : no_pic;
      default:         p = no_pic;
    endcase
    return p;
  endfunction

endpackage

### rtl/core/motor_fault_alarm_supervisor.sv
// motor_fault_alarm_supervisor: alarm lifecycle control for motor driver fault codes
//
//  channel   | direction | transfer contents
//  ----------+-----------+------------------------------------------------------
//  s_axis    | in        | status frame or foot release notice (tuser = kind)
//  m_axis    | out       | one result per input transfer
//  cfg       | in        | register write, index 0..7, 16-bit data
//
// every input transfer is handled in a single pass: decode, state update and result
// are done together into the result register, so one transfer is taken per cycle
// while the output side keeps up. results appear in the cycle after acceptance.
// rst is synchronous; it empties the result register and restores registers
// and lifecycle state. a stalled output holds its result and s_tready drops.
module motor_fault_alarm_supervisor
  import mfas_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // drv_fault[7:0], now_ms[39:8], foot_running[40],
                                         // alarm_shown[41], shown_alarm[49:42], zeros above
  input  logic                s_tuser,   // kind: 0 status frame, 1 foot release notice
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // raise_alarm[0], alarm_code[8:1], picture_code[16:9],
                                         // clear_alarm[17], stop_all_work[18], stop_pumps[19],
                                         // waiting_release[20], zeros above
  // configuration writes
  input  logic                cfg_wen,
  input  logic [CfgIdxW-1:0]  cfg_addr,
  input  logic [CfgDataW-1:0] cfg_data
);

  // configuration registers
  logic        detail_mode;
  logic [15:0] hold_ms;
  logic [7:0]  overload_code, voltage_code, hall_code, board_code;
  logic [7:0]  handle_lost_code, no_picture_code;

  // lifecycle state
  logic [7:0]  owned_alarm, last_fault;
  logic [31:0] alarm_start;
  logic        recovered, wait_foot, release_seen, fault_seen;
  logic [7:0]  owned_alarm_next, last_fault_next;
  logic [31:0] alarm_start_next;
  logic        recovered_next, wait_foot_next, release_seen_next, fault_seen_next;

  in_item_t    item;
  result_t     res;
  result_t     res_q;
  logic        accept;

  // decode helpers
  logic [7:0]  map_a, map_p;
  logic [31:0] elapsed;
  logic        own_match, hold_short;
  logic        tc_blocked, tc_skip, tc_end, tc_clr;
  logic        tc_rec, tc_rs;
  logic        do_try;

  assign item     = in_item_t'(s_tdata[InItemW-1:0]);
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      detail_mode      <= DETAIL_MODE_RST;
      hold_ms          <= HOLD_MS_RST;
      overload_code    <= OVERLOAD_CODE_RST;
      voltage_code     <= VOLTAGE_CODE_RST;
      hall_code        <= HALL_CODE_RST;
      board_code       <= BOARD_CODE_RST;
      handle_lost_code <= HANDLE_LOST_RST;
      no_picture_code  <= NO_PICTURE_RST;
    end else if (cfg_wen) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_DETAIL_MODE:   detail_mode      <= cfg_data[0];
        CFG_HOLD_MS:       hold_ms          <= cfg_data;
        CFG_OVERLOAD_CODE: overload_code    <= cfg_data[7:0];
        CFG_VOLTAGE_CODE:  voltage_code     <= cfg_data[7:0];
        CFG_HALL_CODE:     hall_code        <= cfg_data[7:0];
        CFG_BOARD_CODE:    board_code       <= cfg_data[7:0];
        CFG_HANDLE_LOST:   handle_lost_code <= cfg_data[7:0];
        CFG_NO_PICTURE:    no_picture_code  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // fault code mapping
  assign map_a = map_alarm(item.drv_fault, overload_code, voltage_code, hall_code,
                           board_code);
  assign map_p = map_picture(item.drv_fault, detail_mode, no_picture_code);

  // clear attempt: shared by release notices and recovery frames
  assign elapsed    = item.now_ms - alarm_start;
  assign own_match  = (owned_alarm != 8'd0) && item.alarm_shown &&
                      (item.shown_alarm == owned_alarm);
  assign tc_rec     = s_tuser ? recovered : 1'b1;
  assign tc_rs      = s_tuser ? 1'b1 : release_seen;
  assign tc_skip    = s_tuser || wait_foot;
  assign tc_blocked = wait_foot && (!tc_rs || !tc_rec);
  assign hold_short = own_match && !tc_skip && (elapsed < {16'd0, hold_ms});
  assign tc_end     = !tc_blocked && !hold_short;
  assign tc_clr     = tc_end && own_match;
  assign do_try     = s_tuser ? (wait_foot && recovered) : (item.drv_fault == ERR_NONE);

  // next state and result for one event
  always_comb begin
    owned_alarm_next  = owned_alarm;
    last_fault_next   = last_fault;
    alarm_start_next  = alarm_start;
    recovered_next    = recovered;
    wait_foot_next    = wait_foot;
    release_seen_next = release_seen;
    fault_seen_next   = fault_seen;
    res               = '0;
    res.picture_code  = no_picture_code;

    if (s_tuser) begin
      // foot release notice
      if (wait_foot) begin
        release_seen_next = 1'b1;
      end
    end else if (item.drv_fault == ERR_NONE) begin
      // recovery frame
      recovered_next = 1'b1;
      if (fault_seen) begin
        fault_seen_next   = 1'b0;
        res.stop_all_work = 1'b1;
      end
    end else begin
      // fault frame
      fault_seen_next = 1'b1;
      res.stop_pumps  = 1'b1;
      if ((item.shown_alarm != handle_lost_code) && (map_a != 8'd0)) begin
        recovered_next = 1'b0;
        if (!((last_fault == item.drv_fault) && (owned_alarm == map_a) &&
              item.alarm_shown && (item.shown_alarm == map_a))) begin
          if (owned_alarm == 8'd0) begin
            wait_foot_next    = item.foot_running;
            release_seen_next = 1'b0;
          end
          last_fault_next  = item.drv_fault;
          owned_alarm_next = map_a;
          alarm_start_next = item.now_ms;
          res.raise_alarm  = 1'b1;
          res.alarm_code   = map_a;
          res.picture_code = map_p;
        end
      end
    end

    // end of lifecycle after a clear attempt that got through
    if (do_try) begin
      res.clear_alarm = tc_clr;
      if (tc_end) begin
        owned_alarm_next  = 8'd0;
        last_fault_next   = 8'd0;
        alarm_start_next  = 32'd0;
        recovered_next    = 1'b0;
        wait_foot_next    = 1'b0;
        release_seen_next = 1'b0;
      end
    end

    res.waiting_release = wait_foot_next && !release_seen_next;
  end

  // lifecycle state update
  always_ff @(posedge clk) begin
    if (rst) begin
      owned_alarm  <= 8'd0;
      last_fault   <= 8'd0;
      alarm_start  <= 32'd0;
      recovered    <= 1'b0;
      wait_foot    <= 1'b0;
      release_seen <= 1'b0;
      fault_seen   <= 1'b0;
    end else if (accept) begin
      owned_alarm  <= owned_alarm_next;
      last_fault   <= last_fault_next;
      alarm_start  <= alarm_start_next;
      recovered    <= recovered_next;
      wait_foot    <= wait_foot_next;
      release_seen <= release_seen_next;
      fault_seen   <= fault_seen_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_tdata = {{(OutDataW-ResultW){1'b0}}, res_q};

endmodule

### rtl/core/mfas_checker.sv
// mfas_checker: port-level assertions for the motor fault alarm supervisor, with bind
module mfas_checker
  import mfas_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  result_t r;
  assign r = result_t'(m_tdata[ResultW-1:0]);

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // an input transfer always yields a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item gave no result");

  // a raised alarm comes from a fault frame and carries a nonzero code
  a_raise_fault: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.raise_alarm |-> r.stop_pumps && (r.alarm_code != 8'd0) && !r.clear_alarm)
    else $error("raise without fault frame or code");

  // without a raise the alarm code is zero, and a fault frame never revokes work
  a_quiet_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (r.raise_alarm || (r.alarm_code == 8'd0)) &&
                 !(r.stop_pumps && (r.stop_all_work || r.clear_alarm)))
    else $error("inconsistent result flags");

endmodule

bind motor_fault_alarm_supervisor mfas_checker u_mfas_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### bench/mfas_checker.sv
// mfas_scoreboard: result predictor and scoreboard for the motor fault alarm supervisor
`timescale 1ns / 1ps

module mfas_scoreboard
  import mfas_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // drv_fault, now_ms, foot_running, alarm_shown,
                                         // shown_alarm, zeros above
  input  logic                s_tuser,   // kind: 0 status frame, 1 foot release notice
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [OutDataW-1:0] m_tdata,   // raise_alarm, alarm_code, picture_code, clear_alarm,
                                         // stop_all_work, stop_pumps, waiting_release
  input  logic                cfg_wen,
  input  logic [CfgIdxW-1:0]  cfg_addr,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  errors,
  output int                  outstanding
);

  int mismatches  = 0;
  int waiting_cnt = 0;

  assign errors      = mismatches;
  assign outstanding = waiting_cnt;

  // shadow copies of the configuration registers
  logic        detail_r;
  logic [15:0] hold_r;
  logic [7:0]  overload_r, voltage_r, hall_r, board_r, handle_lost_r, no_pic_r;

  // alarm lifecycle state
  logic [7:0]  owned_q, last_err_q;
  logic [31:0] start_q;
  logic        recovered_q, foot_wait_q, released_q, fault_q;

  // results still owed by the block, oldest first
  result_t due_results[$];

  // alarm code that a raw fault code maps to
  function automatic logic [7:0] alarm_for(input logic [7:0] err);
    case (err)
      ERR_NONE:                          return 8'd0;
      ERR_OVERCURRENT, ERR_RUN_STALL:    return overload_r;
      ERR_OVERVOLTAGE, ERR_UNDERVOLTAGE: return voltage_r;
      ERR_HALL_DISC, ERR_HALL_LEARN:     return hall_r;
      default:                           return board_r;
    endcase
  endfunction

  // screen picture for a raw fault code, debug set when detail mode is on
  function automatic logic [7:0] picture_for(input logic [7:0] err);
    if (err == ERR_PHASE_LOSS) return PIC_PHASE_LOSS;
    if (err == ERR_RUN_STALL) return PIC_OVERLOAD;
    if (detail_r) begin
      case (err)
        ERR_OVERCURRENT: return PIC_DBG_OVERCUR;
        ERR_HALL_DISC:   return PIC_DBG_HALL_D;
        ERR_HALL_LEARN:  return PIC_DBG_HALL_L;
        ERR_CODE_9:      return PIC_DBG_9;
        ERR_CODE_10:     return PIC_DBG_10;
        ERR_OVERVOLTAGE: return PIC_DBG_OVERVOLT;
        ERR_CODE_6:      return PIC_DBG_6;
        ERR_CODE_15:     return PIC_DBG_15;
        ERR_CODE_8:      return PIC_DBG_8;
        default:         return no_pic_r;
      endcase
    end
    case (err)
      ERR_OVERCURRENT:               return PIC_OVERLOAD;
      ERR_HALL_DISC, ERR_HALL_LEARN: return PIC_HALL_SHARED;
      default:                       return no_pic_r;
    endcase
  endfunction

  function automatic void drop_lifecycle();
    owned_q     = 8'd0;
    last_err_q  = 8'd0;
    start_q     = 32'd0;
    recovered_q = 1'b0;
    foot_wait_q = 1'b0;
    released_q  = 1'b0;
  endfunction

  // clear attempt; returns 1 when the system alarm is to be cleared
  function automatic logic settle_alarm(input logic skip_hold, input logic [31:0] now,
                                        input logic shown, input logic [7:0] code);
    logic skip_all;
    logic clr;
    skip_all = skip_hold;
    clr      = 1'b0;
    // foot-sourced fault needs both release and recovery, then ignores hold time
    if (foot_wait_q) begin
      if (!released_q || !recovered_q) return 1'b0;
      skip_all = 1'b1;
    end
    if (owned_q != 8'd0 && shown && code == owned_q) begin
      if (!skip_all && (now - start_q) < 32'(hold_r)) return 1'b0;
      clr = 1'b1;
    end
    // an alarm that is not ours just drops ownership
    drop_lifecycle();
    return clr;
  endfunction

  // next supervisor result for one event, updates the lifecycle state
  function automatic result_t next_alarm_result(input logic is_release, input in_item_t ev);
    result_t    r;
    logic [7:0] acode;
    r              = '0;
    r.picture_code = no_pic_r;
    if (is_release) begin
      if (foot_wait_q) begin
        released_q = 1'b1;
        if (recovered_q)
          r.clear_alarm = settle_alarm(1'b1, ev.now_ms, ev.alarm_shown, ev.shown_alarm);
      end
    end else if (ev.drv_fault == ERR_NONE) begin
      // recovery frame: first one after a fault revokes all work
      recovered_q = 1'b1;
      if (fault_q) begin
        fault_q         = 1'b0;
        r.stop_all_work = 1'b1;
      end
      r.clear_alarm = settle_alarm(1'b0, ev.now_ms, ev.alarm_shown, ev.shown_alarm);
    end else begin
      fault_q      = 1'b1;
      r.stop_pumps = 1'b1;
      acode        = alarm_for(ev.drv_fault);
      // handle lost alarm held or unmapped code: nothing raised
      if (ev.shown_alarm != handle_lost_r && acode != 8'd0) begin
        recovered_q = 1'b0;
        if (!(last_err_q == ev.drv_fault && owned_q == acode && ev.alarm_shown &&
              ev.shown_alarm == acode)) begin
          if (owned_q == 8'd0) begin
            foot_wait_q = ev.foot_running;
            released_q  = 1'b0;
          end
          last_err_q     = ev.drv_fault;
          owned_q        = acode;
          start_q        = ev.now_ms;
          r.raise_alarm  = 1'b1;
          r.alarm_code   = acode;
          r.picture_code = picture_for(ev.drv_fault);
        end
      end
    end
    r.waiting_release = foot_wait_q && !released_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // watch all three channels at each edge
  always @(posedge clk) begin
    in_item_t ev;
    result_t  got;
    result_t  want;
    if (rst) begin
      detail_r      = DETAIL_MODE_RST;
      hold_r        = HOLD_MS_RST;
      overload_r    = OVERLOAD_CODE_RST;
      voltage_r     = VOLTAGE_CODE_RST;
      hall_r        = HALL_CODE_RST;
      board_r       = BOARD_CODE_RST;
      handle_lost_r = HANDLE_LOST_RST;
      no_pic_r      = NO_PICTURE_RST;
      drop_lifecycle();
      fault_q = 1'b0;
      due_results.delete();
    end else begin
      // result transfer against the oldest expectation
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[ResultW-1:0]);
        if (due_results.size() == 0) begin
          report_mismatch("result with no item waiting", int'(got), 0);
        end else begin
          want = due_results.pop_front();
          if (got.raise_alarm !== want.raise_alarm)
            report_mismatch("raise_alarm", got.raise_alarm, want.raise_alarm);
          if (got.alarm_code !== want.alarm_code)
            report_mismatch("alarm_code", got.alarm_code, want.alarm_code);
          if (got.picture_code !== want.picture_code)
            report_mismatch("picture_code", got.picture_code, want.picture_code);
          if (got.clear_alarm !== want.clear_alarm)
            report_mismatch("clear_alarm", got.clear_alarm, want.clear_alarm);
          if (got.stop_all_work !== want.stop_all_work)
            report_mismatch("stop_all_work", got.stop_all_work, want.stop_all_work);
          if (got.stop_pumps !== want.stop_pumps)
            report_mismatch("stop_pumps", got.stop_pumps, want.stop_pumps);
          if (got.waiting_release !== want.waiting_release)
            report_mismatch("waiting_release", got.waiting_release, want.waiting_release);
        end
      end
      // register writes
      if (cfg_wen) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_DETAIL_MODE:   detail_r      = cfg_data[0];
          CFG_HOLD_MS:       hold_r        = cfg_data;
          CFG_OVERLOAD_CODE: overload_r    = cfg_data[7:0];
          CFG_VOLTAGE_CODE:  voltage_r     = cfg_data[7:0];
          CFG_HALL_CODE:     hall_r        = cfg_data[7:0];
          CFG_BOARD_CODE:    board_r       = cfg_data[7:0];
          CFG_HANDLE_LOST:   handle_lost_r = cfg_data[7:0];
          CFG_NO_PICTURE:    no_pic_r      = cfg_data[7:0];
          default: ;
        endcase
      end
      // input transfer
      if (s_tvalid && s_tready) begin
        ev = in_item_t'(s_tdata[InItemW-1:0]);
        due_results.push_back(next_alarm_result(s_tuser, ev));
      end
    end
    waiting_cnt <= due_results.size();
  end

endmodule

### bench/tb_motor_fault_alarm_supervisor.sv
// tb_motor_fault_alarm_supervisor: stimulus, clock, reset and verdict for the alarm supervisor
`timescale 1ns / 1ps

module tb_motor_fault_alarm_supervisor;
  import mfas_pkg::*;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_wen  = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr = CFG_DETAIL_MODE;
  logic [CfgDataW-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int items_sent = 0;
  bit idle_en    = 1'b1;

  // stimulus copies of the alarm codes, used to aim shown_alarm at live codes
  logic [15:0] hold_cur   = HOLD_MS_RST;
  logic [7:0]  code_ovl   = OVERLOAD_CODE_RST;
  logic [7:0]  code_volt  = VOLTAGE_CODE_RST;
  logic [7:0]  code_hall  = HALL_CODE_RST;
  logic [7:0]  code_board = BOARD_CODE_RST;
  logic [7:0]  code_hl    = HANDLE_LOST_RST;
  logic [31:0] tick       = 32'd0;

  motor_fault_alarm_supervisor i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  mfas_scoreboard i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wen     (cfg_wen),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .errors      (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side stalls at random while idling is enabled
  always @(posedge clk) begin
    m_tready <= !idle_en || ($urandom_range(99) >= 7);
  end

  // one event transfer, with random idle cycles ahead of it
  task automatic send_event(input logic kind, input logic [7:0] err, input logic [31:0] now,
                            input logic foot, input logic shown, input logic [7:0] code);
    in_item_t ev;
    ev.drv_fault    = err;
    ev.now_ms       = now;
    ev.foot_running = foot;
    ev.alarm_shown  = shown;
    ev.shown_alarm  = code;
    while (idle_en && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(InDataW - InItemW){1'b0}}, ev};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // write all eight registers, block idle
  task automatic load_settings(input logic detail, input logic [15:0] hold,
                               input logic [7:0] ovl, input logic [7:0] volt,
                               input logic [7:0] hall, input logic [7:0] board,
                               input logic [7:0] hl, input logic [7:0] nopic);
    logic [15:0] vals [8];
    vals = '{16'(detail), hold, 16'(ovl), 16'(volt), 16'(hall), 16'(board), 16'(hl),
             16'(nopic)};
    for (int i = 0; i < 8; i++) begin
      cfg_wen  <= 1'b1;
      cfg_addr <= cfg_idx_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_wen    <= 1'b0;
    hold_cur   = hold;
    code_ovl   = ovl;
    code_volt  = volt;
    code_hall  = hall;
    code_board = board;
    code_hl    = hl;
  endtask

  // shown_alarm mostly set to one of the live alarm codes
  function automatic logic [7:0] pick_code();
    case ($urandom_range(9))
      0, 1:    return code_ovl;
      2:       return code_volt;
      3:       return code_hall;
      4, 5:    return code_board;
      6:       return code_hl;
      7:       return 8'd0;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_fault();
    case ($urandom_range(13))
      0:       return ERR_OVERCURRENT;
      1:       return ERR_OVERVOLTAGE;
      2:       return ERR_UNDERVOLTAGE;
      3:       return ERR_RUN_STALL;
      4:       return ERR_CODE_6;
      5:       return ERR_CODE_8;
      6:       return ERR_CODE_9;
      7:       return ERR_CODE_10;
      8:       return ERR_HALL_DISC;
      9:       return ERR_HALL_LEARN;
      10:      return ERR_PHASE_LOSS;
      11:      return ERR_CODE_15;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // millisecond tick moves on, mostly in small steps, sometimes jumps anywhere
  function automatic logic [31:0] bump_tick();
    case ($urandom_range(19))
      0:             tick = $urandom();
      1, 2, 3, 4, 5: tick = tick + 32'($urandom_range(0, 2 * hold_cur + 10));
      default:       tick = tick + 32'($urandom_range(0, 400));
    endcase
    return tick;
  endfunction

  // one fault episode: fault frames, recoveries and pedal releases, plus some noise
  task automatic run_episode();
    logic [7:0] err;
    logic       foot;
    err  = pick_fault();
    foot = 1'($urandom_range(1));
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(4) == 0) err = pick_fault();
      send_event(1'b0, err, bump_tick(), foot ^ ($urandom_range(9) == 0),
                 $urandom_range(9) != 0, pick_code());
    end
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(9) < 3)
        send_event(1'b1, 8'($urandom_range(255)), bump_tick(), 1'($urandom_range(1)),
                   $urandom_range(9) != 0, pick_code());
      send_event(1'b0, ERR_NONE, bump_tick(), 1'($urandom_range(1)),
                 $urandom_range(9) != 0, pick_code());
    end
    if ($urandom_range(1))
      send_event(1'b1, 8'($urandom_range(255)), bump_tick(), 1'($urandom_range(1)),
                 $urandom_range(9) != 0, pick_code());
    if ($urandom_range(4) == 0)
      send_event(1'($urandom_range(1)), 8'($urandom_range(255)), $urandom(),
                 1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  initial begin
    logic [7:0] singles [9];
    int         phase_end;
    singles = '{ERR_OVERVOLTAGE, ERR_UNDERVOLTAGE, ERR_CODE_6, ERR_CODE_8, ERR_CODE_9,
                ERR_CODE_10, ERR_CODE_15, 8'd1, 8'd13};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset settings
    send_event(1'b0, ERR_NONE, 32'd0, 1'b0, 1'b0, 8'd0);           // recovery, no fault
    send_event(1'b1, 8'd0, 32'd10, 1'b0, 1'b0, 8'd0);              // release, no foot fault
    send_event(1'b0, ERR_OVERCURRENT, 32'd100, 1'b0, 1'b0, 8'd0);
    send_event(1'b0, ERR_OVERCURRENT, 32'd150, 1'b0, 1'b1, OVERLOAD_CODE_RST); // repeat
    send_event(1'b0, ERR_NONE, 32'd200, 1'b0, 1'b1, OVERLOAD_CODE_RST);  // hold not met
    send_event(1'b0, ERR_NONE, 32'd3100, 1'b0, 1'b1, OVERLOAD_CODE_RST); // hold met
    // foot-sourced fault across the tick wrap
    send_event(1'b0, ERR_PHASE_LOSS, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'd0);
    send_event(1'b0, ERR_NONE, 32'd0, 1'b1, 1'b1, BOARD_CODE_RST);
    send_event(1'b1, 8'hFF, 32'h20, 1'b0, 1'b1, BOARD_CODE_RST);
    // handle lost alarm held
    send_event(1'b0, ERR_RUN_STALL, 32'h100, 1'b0, 1'b1, HANDLE_LOST_RST);
    send_event(1'b0, 8'hFF, 32'h200, 1'b0, 1'b0, 8'd0);
    send_event(1'b0, ERR_HALL_DISC, 32'h300, 1'b0, 1'b1, BOARD_CODE_RST);
    // alarm shown is not ours
    send_event(1'b0, ERR_NONE, 32'h400, 1'b0, 1'b1, 8'hFF);
    // elapsed time across the wrap
    send_event(1'b0, ERR_HALL_LEARN, 32'hFFFF_FFF0, 1'b0, 1'b0, 8'd0);
    send_event(1'b0, ERR_NONE, 32'h10, 1'b0, 1'b1, HALL_CODE_RST);
    send_event(1'b0, ERR_NONE, 32'd2984, 1'b0, 1'b1, HALL_CODE_RST);
    foreach (singles[i])
      send_event(1'b0, singles[i], 32'd5000 + 32'(i), 1'b0, 1'b0, 8'd0);
    drain_results();

    // random phases, each with its own register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_settings(1'b1, 16'd0, 8'd2, 8'd3, 8'd4, 8'd6, 8'd255, 8'd0);
        1: load_settings(1'b0, 16'hFFFF, 8'd0, 8'd255, 8'd0, 8'd1, 8'd1, 8'd255);
        2: load_settings(1'b1, 16'($urandom_range(65535)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                         8'($urandom_range(255)));
        3: load_settings(1'b0, 16'd500, 8'd7, 8'd7, 8'd7, 8'd7, 8'd200, PIC_PHASE_LOSS);
        4: load_settings(1'b1, HOLD_MS_RST, OVERLOAD_CODE_RST, 8'd0, HALL_CODE_RST,
                         BOARD_CODE_RST, 8'd255, NO_PICTURE_RST);
        default: load_settings(1'($urandom_range(1)), 16'($urandom_range(2000)),
                               8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)), 8'($urandom_range(1, 255)),
                               8'($urandom_range(1, 255)), 8'($urandom_range(255)));
      endcase
      // one phase runs with no idling on either side
      idle_en = (ph != 1);
      tick = ($urandom_range(3) == 0) ? 32'hFFFF_0000 + 32'($urandom_range(65535)) : $urandom();
      phase_end = items_sent + 200;
      while (items_sent < phase_end) begin
        run_episode();
        if (ph == 3 && items_sent >= phase_end - 100 && items_sent < phase_end - 90)
          drain_results();
      end
      drain_results();
    end
    idle_en = 1'b1;

    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("motor_fault_alarm_supervisor test passed");
    else
      $display("motor_fault_alarm_supervisor test failed");
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("motor_fault_alarm_supervisor test failed");
    $finish;
  end

endmodule

### filelist.f
rtl/core/mfas_pkg.sv
rtl/core/motor_fault_alarm_supervisor.sv
rtl/core/mfas_checker.sv
bench/mfas_checker.sv
bench/tb_motor_fault_alarm_supervisor.sv
